FILE: hdl/ffrs_pkg.sv
// ----------------------------------------------------------------------------
// ffrs_pkg
// constants and types shared by the fixed frame receiver with 16-bit sum
// ----------------------------------------------------------------------------
package ffrs_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned SUM_W         = 16;
  localparam int unsigned PAYLOAD_BYTES = 16;
  localparam int unsigned PIDX_W        = 4;
  localparam int unsigned HALF_W        = 64;

  localparam logic [BYTE_W-1:0] FRAME_HEAD0 = 8'hBB;
  localparam logic [BYTE_W-1:0] FRAME_HEAD1 = 8'hAA;
  localparam logic [BYTE_W-1:0] FRAME_ADDR  = 8'h00;

  localparam logic [POS_W-1:0] POS_HEAD0   = 5'd0;
  localparam logic [POS_W-1:0] POS_HEAD1   = 5'd1;
  localparam logic [POS_W-1:0] POS_ADDR    = 5'd2;
  localparam logic [POS_W-1:0] POS_CMD     = 5'd3;
  localparam logic [POS_W-1:0] POS_ENC     = 5'd4;
  localparam logic [POS_W-1:0] POS_LEN     = 5'd5;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 5'd6;
  localparam logic [POS_W-1:0] POS_SUM_LO  = 5'd22;
  localparam logic [POS_W-1:0] POS_SUM_HI  = 5'd23;

  localparam int unsigned OUT_DATA_W = 3 * BYTE_W + 2 * HALF_W + SUM_W;

  typedef struct packed {
    logic [SUM_W-1:0]  frame_sum;
    logic [HALF_W-1:0] payload_high;
    logic [HALF_W-1:0] payload_low;
    logic [BYTE_W-1:0] frame_len;
    logic [BYTE_W-1:0] frame_encode;
    logic [BYTE_W-1:0] frame_cmd;
  } frame_res_t;

endpackage

FILE: hdl/ffrs_parser.sv
// ----------------------------------------------------------------------------
// ffrs_parser
// frame position tracking, header check, running sum and field capture
// ----------------------------------------------------------------------------
module ffrs_parser import ffrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_go,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              res_valid,
  output frame_res_t        res
);

  logic [POS_W-1:0]  pos_r, pos_nxt, pos_eff;
  logic [SUM_W-1:0]  sum_r, sum_nxt, sum_add;
  logic [BYTE_W-1:0] cmd_r, enc_r, len_r, sum_lo_r;
  logic [BYTE_W-1:0] payload_r [PAYLOAD_BYTES];
  logic [POS_W-1:0]  pidx_full;
  logic              pl_wr;
  logic [SUM_W-1:0]  rx_sum;

  assign pos_eff   = (pos_r > POS_SUM_HI) ? POS_HEAD0 : pos_r;
  assign sum_add   = sum_r + {{(SUM_W-BYTE_W){1'b0}}, rx_byte};
  assign pidx_full = pos_eff - POS_PAYLOAD;
  assign pl_wr     = byte_go && (pos_eff >= POS_PAYLOAD) && (pos_eff < POS_SUM_LO);
  assign rx_sum    = {rx_byte, sum_lo_r};

  always_comb begin
    pos_nxt = pos_eff + 5'd1;
    sum_nxt = sum_r;
    priority if (pos_eff == POS_HEAD0) begin
      if (rx_byte == FRAME_HEAD0) begin
        sum_nxt = {{(SUM_W-BYTE_W){1'b0}}, rx_byte};
      end else begin
        pos_nxt = POS_HEAD0;
      end
    end else if (pos_eff == POS_HEAD1 && rx_byte != FRAME_HEAD1) begin
      pos_nxt = POS_HEAD0;
    end else if (pos_eff == POS_ADDR && rx_byte != FRAME_ADDR) begin
      pos_nxt = POS_HEAD0;
    end else if (pos_eff == POS_SUM_HI) begin
      pos_nxt = POS_HEAD0;
    end else if (pos_eff < POS_SUM_LO) begin
      sum_nxt = sum_add;
    end else begin
      sum_nxt = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_HEAD0;
      sum_r    <= '0;
      cmd_r    <= '0;
      enc_r    <= '0;
      len_r    <= '0;
      sum_lo_r <= '0;
    end else if (byte_go) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      if (pos_eff == POS_CMD)    cmd_r    <= rx_byte;
      if (pos_eff == POS_ENC)    enc_r    <= rx_byte;
      if (pos_eff == POS_LEN)    len_r    <= rx_byte;
      if (pos_eff == POS_SUM_LO) sum_lo_r <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (pl_wr) begin
      payload_r[pidx_full[PIDX_W-1:0]] <= rx_byte;
    end
  end

  always_comb begin
    res.frame_cmd    = cmd_r;
    res.frame_encode = enc_r;
    res.frame_len    = len_r;
    res.frame_sum    = sum_r;
    for (int i = 0; i < PAYLOAD_BYTES / 2; i++) begin
      res.payload_low[i*BYTE_W +: BYTE_W]  = payload_r[i];
      res.payload_high[i*BYTE_W +: BYTE_W] = payload_r[i + PAYLOAD_BYTES / 2];
    end
  end

  assign res_valid = byte_go && (pos_eff == POS_SUM_HI) && (rx_sum == sum_r);

endmodule

FILE: hdl/ffrs_out_reg.sv
// ----------------------------------------------------------------------------
// ffrs_out_reg
// result register with skid stage toward the master-side stream
// ----------------------------------------------------------------------------
module ffrs_out_reg import ffrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_valid,
  input  frame_res_t            res,
  output logic                  res_ready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic       main_vld_r, main_vld_nxt;
  logic       skid_vld_r, skid_vld_nxt;
  frame_res_t main_r, skid_r;
  logic       pop;
  logic       load_main, load_skid, move_skid;

  assign res_ready = !skid_vld_r;
  assign pop       = main_vld_r && out_tready;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    load_main    = 1'b0;
    load_skid    = 1'b0;
    move_skid    = 1'b0;
    if (pop) begin
      main_vld_nxt = 1'b0;
    end
    if (skid_vld_r && !main_vld_nxt) begin
      move_skid    = 1'b1;
      main_vld_nxt = 1'b1;
      skid_vld_nxt = 1'b0;
    end
    if (res_valid) begin
      if (!main_vld_nxt) begin
        load_main    = 1'b1;
        main_vld_nxt = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move_skid) begin
      main_r <= skid_r;
    end else if (load_main) begin
      main_r <= res;
    end
    if (load_skid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = main_vld_r;
  assign out_tdata  = main_r;

endmodule

FILE: hdl/fixed_frame_receiver_sum16_unit.sv
// ----------------------------------------------------------------------------
// fixed_frame_receiver_sum16_unit
// assembles fixed 24-byte frames from a byte stream and emits frames whose
// 16-bit sum matches the received checksum
// ----------------------------------------------------------------------------
// throughput: one byte transaction per cycle while the skid register is empty, set by the single-pass parser
// path: the last byte of a frame is taken into the input register, and the frame
//   result is then loaded into the result register (or the skid register)
// reset: synchronous active-low rst_n returns the parser to the first header
//   byte and empties the input, result and skid registers
// ----------------------------------------------------------------------------
module fixed_frame_receiver_sum16_unit import ffrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // frame_cmd, frame_encode, frame_len,
                                            // payload_low, payload_high, frame_sum
);

  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              res_ready;
  logic              byte_go;
  logic              res_valid;
  frame_res_t        res;

  assign byte_go   = in_vld_r && res_ready;
  assign in_tready = !in_vld_r || res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  ffrs_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_go   (byte_go),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  ffrs_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
